>>> src/bllca_pkg.sv
// Shared widths and operation codes of the binary lifting common-ancestor block.
// No dependencies; imported by the top level and by its checker.
`default_nettype none

package bllca_pkg;

  localparam int NODE_W   = 10;  // node number field
  localparam int DIST_W   = 11;  // path length field
  localparam int S_DATA_W = 24;  // first_node, second_node, zero fill
  localparam int M_DATA_W = 24;  // ancestor_node, distance, zero fill

  localparam logic OP_ATTACH = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

endpackage

`default_nettype wire

>>> src/bllca_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the jump and depth tables of the top level.
`default_nettype none

module bllca_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/binary_lifting_lca.sv
// Top level of the binary lifting lowest-common-ancestor block: stream ports,
// sequencer and two table RAMs. Depends on bllca_pkg and bllca_ram.
//
// The block keeps, for every node, its 2^i-th ancestors (i below LEVELS) in a
// jump-table RAM and its depth in a depth RAM. A word with tuser = 0 attaches
// first_node under second_node (0 makes a root); parents go in before their
// children, and nothing comes back. A word with tuser = 1 asks for the lowest
// common ancestor of the two nodes and returns one word with the ancestor and
// the number of edges between them. One word is in work at a time: s_axis_tready
// is high only while the sequencer is idle. Each table has a single read
// port, so every lift step reads a jump entry, then the depth of the node it
// points to. The result sits in an output register, so a held result only
// stalls the block at the end of the next query. Node 0 is the sentinel; its
// entries are never written and read as zero, so no clearing pass runs after
// reset. Entries of nodes never attached hold whatever the RAM powers up with.
`default_nettype none

module binary_lifting_lca #(
  parameter int MAX_NODES = 1023,
  parameter int LEVELS    = 10
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [9:0] first_node, [19:10] second_node, [23:20] zero
  input  wire logic [bllca_pkg::S_DATA_W-1:0] s_axis_tdata,
  // [0] opcode
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [9:0] ancestor_node, [20:10] distance, [23:21] zero
  output logic      [bllca_pkg::M_DATA_W-1:0] m_axis_tdata
);

  import bllca_pkg::*;

  // Storage only covers nodes that can be addressed at all.
  localparam int NODE_TOP = (MAX_NODES < (1 << NODE_W) - 1) ? MAX_NODES : (1 << NODE_W) - 1;
  localparam int NODES    = NODE_TOP + 1;
  localparam int NA_W     = $clog2(NODES);
  localparam int JA_W     = $clog2(NODES * LEVELS);
  localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);

  // Sequencer codes
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_A_CHK  = 5'd1;   // check attach, read parent depth
  localparam logic [4:0] ST_A_DEP  = 5'd2;   // write depth and level 0
  localparam logic [4:0] ST_A_RD   = 5'd3;   // read jump[mid][lvl-1]
  localparam logic [4:0] ST_A_WR   = 5'd4;   // write jump[node][lvl]
  localparam logic [4:0] ST_Q_DA   = 5'd5;   // read depth of a
  localparam logic [4:0] ST_Q_DB   = 5'd6;   // read depth of b
  localparam logic [4:0] ST_Q_SW   = 5'd7;   // order so that a is deeper
  localparam logic [4:0] ST_L_RJ   = 5'd8;   // lift: read jump[a][lvl]
  localparam logic [4:0] ST_L_RD   = 5'd9;   // lift: read depth of candidate
  localparam logic [4:0] ST_L_CMP  = 5'd10;  // lift: take step if not too high
  localparam logic [4:0] ST_L_EQ   = 5'd11;
  localparam logic [4:0] ST_C_RA   = 5'd12;  // climb: read jump[a][lvl]
  localparam logic [4:0] ST_C_RB   = 5'd13;  // climb: read jump[b][lvl]
  localparam logic [4:0] ST_C_CMP  = 5'd14;
  localparam logic [4:0] ST_C_FIN  = 5'd15;  // read jump[a][0]
  localparam logic [4:0] ST_C_LCA  = 5'd16;
  localparam logic [4:0] ST_F_RD   = 5'd17;  // read depth of ancestor
  localparam logic [4:0] ST_F_DIST = 5'd18;
  localparam logic [4:0] ST_Q_OUT  = 5'd19;

  logic [4:0]         state;
  logic [NODE_W-1:0]  a;        // attach: node; query: first walker
  logic [NODE_W-1:0]  b;        // attach: parent; query: second walker
  logic [NODE_W-1:0]  cur;      // attach: current mid node
  logic [NODE_W-1:0]  up;       // candidate node of a step
  logic [NODE_W-1:0]  lca;
  logic [NODE_W-1:0]  da;
  logic [NODE_W-1:0]  tgt;      // depth of the shallower node
  logic [DIST_W-1:0]  sum;      // depth(a) + depth(b)
  logic [LVL_W-1:0]   lvl;
  logic [NODE_W-1:0]  res_anc;
  logic [DIST_W-1:0]  res_dist;
  logic [NODE_W-1:0]  out_anc;
  logic [DIST_W-1:0]  out_dist;

  // Table ports
  logic [NODE_W-1:0]  j_rnode;
  logic [LVL_W-1:0]   j_rlvl;
  logic [NODE_W-1:0]  d_rnode;
  logic               j_we;
  logic [LVL_W-1:0]   j_wlvl;
  logic [NODE_W-1:0]  j_wdata;
  logic               d_we;
  logic [NODE_W-1:0]  d_wdata;
  logic [NODE_W-1:0]  j_rdata;
  logic [NODE_W-1:0]  d_rdata;
  logic               jz;       // last jump read was of node 0
  logic               dz;       // last depth read was of node 0
  logic [NODE_W-1:0]  jq;
  logic [NODE_W-1:0]  jn;       // jq taken as a node number
  logic [NODE_W-1:0]  dq;
  logic [DIST_W-1:0]  twice_d;

  function automatic logic [NODE_W-1:0] node_idx(input logic [NODE_W-1:0] v);
    return (int'(v) > MAX_NODES) ? '0 : v;
  endfunction

  function automatic logic [JA_W-1:0] jaddr(input logic [NODE_W-1:0] n,
                                           input logic [LVL_W-1:0]  l);
    return JA_W'(n[NA_W-1:0]) * JA_W'(LEVELS) + JA_W'(l);
  endfunction

  assign s_axis_tready = (state == ST_IDLE);

  // Node 0 is never written: mask its reads to zero.
  assign jq      = jz ? '0 : j_rdata;
  assign dq      = dz ? '0 : d_rdata;
  assign jn      = node_idx(jq);
  assign twice_d = {dq, 1'b0};

  // Read addresses per step
  always_comb begin
    j_rnode = '0;
    j_rlvl  = '0;
    d_rnode = '0;
    case (state)
      ST_A_CHK: d_rnode = b;
      ST_A_RD: begin
        j_rnode = node_idx(cur);
        j_rlvl  = lvl - LVL_W'(1);
      end
      ST_Q_DA:  d_rnode = node_idx(a);
      ST_Q_DB:  d_rnode = b;
      ST_L_RJ: begin
        j_rnode = a;
        j_rlvl  = lvl;
      end
      ST_L_RD:  d_rnode = jn;
      ST_C_RA: begin
        j_rnode = a;
        j_rlvl  = lvl;
      end
      ST_C_RB: begin
        j_rnode = b;
        j_rlvl  = lvl;
      end
      ST_C_FIN: j_rnode = a;
      ST_F_RD:  d_rnode = lca;
      default: begin
        j_rnode = '0;
      end
    endcase
  end

  // Table writes, attach only
  always_comb begin
    j_we    = 1'b0;
    j_wlvl  = '0;
    j_wdata = b;
    d_we    = 1'b0;
    d_wdata = (&dq) ? dq : dq + NODE_W'(1);  // saturate depth
    case (state)
      ST_A_DEP: begin
        j_we = 1'b1;
        d_we = 1'b1;
      end
      ST_A_WR: begin
        j_we    = 1'b1;
        j_wlvl  = lvl;
        j_wdata = jq;
      end
      default: begin
        j_we = 1'b0;
      end
    endcase
  end

  bllca_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODES * LEVELS)
  ) u_jump (
    .clk   (clk),
    .we    (j_we),
    .waddr (jaddr(a, j_wlvl)),
    .wdata (j_wdata),
    .raddr (jaddr(j_rnode, j_rlvl)),
    .rdata (j_rdata)
  );

  bllca_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODES)
  ) u_depth (
    .clk   (clk),
    .we    (d_we),
    .waddr (a[NA_W-1:0]),
    .wdata (d_wdata),
    .raddr (d_rnode[NA_W-1:0]),
    .rdata (d_rdata)
  );

  always_ff @(posedge clk) begin
    jz <= (j_rnode == '0);
    dz <= (d_rnode == '0);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      // drop valid once taken; the output step reloads it itself
      if (m_axis_tvalid && m_axis_tready && state != ST_Q_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            a     <= s_axis_tdata[NODE_W-1:0];
            b     <= s_axis_tdata[2*NODE_W-1:NODE_W];
            state <= (s_axis_tuser == OP_QUERY) ? ST_Q_DA : ST_A_CHK;
          end
        end
        // Attach
        ST_A_CHK: begin
          // drop attaches of the sentinel or of nodes out of range
          if (a == '0 || int'(a) > MAX_NODES || int'(b) > MAX_NODES) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_A_DEP;
          end
        end
        ST_A_DEP: begin
          cur <= b;
          lvl <= LVL_W'(1);
          state <= (LEVELS == 1) ? ST_IDLE : ST_A_RD;
        end
        ST_A_RD: state <= ST_A_WR;
        ST_A_WR: begin
          cur <= jq;
          if (lvl == LVL_TOP) begin
            state <= ST_IDLE;
          end else begin
            lvl   <= lvl + LVL_W'(1);
            state <= ST_A_RD;
          end
        end
        // Query
        ST_Q_DA: begin
          a     <= node_idx(a);
          b     <= node_idx(b);
          state <= ST_Q_DB;
        end
        ST_Q_DB: begin
          da    <= dq;
          state <= ST_Q_SW;
        end
        ST_Q_SW: begin
          sum <= DIST_W'(da) + DIST_W'(dq);
          lvl <= LVL_TOP;
          if (dq > da) begin
            a   <= b;
            b   <= a;
            tgt <= da;
          end else begin
            tgt <= dq;
          end
          state <= ST_L_RJ;
        end
        ST_L_RJ: state <= ST_L_RD;
        ST_L_RD: begin
          up    <= jn;
          state <= ST_L_CMP;
        end
        ST_L_CMP: begin
          if (dq >= tgt) begin
            a <= up;
          end
          if (lvl == '0) begin
            state <= ST_L_EQ;
          end else begin
            lvl   <= lvl - LVL_W'(1);
            state <= ST_L_RJ;
          end
        end
        ST_L_EQ: begin
          lca   <= a;
          lvl   <= LVL_TOP;
          state <= (a == b) ? ST_F_RD : ST_C_RA;
        end
        ST_C_RA: state <= ST_C_RB;
        ST_C_RB: begin
          up    <= jn;
          state <= ST_C_CMP;
        end
        ST_C_CMP: begin
          if (up != jn) begin
            a <= up;
            b <= jn;
          end
          if (lvl == '0) begin
            state <= ST_C_FIN;
          end else begin
            lvl   <= lvl - LVL_W'(1);
            state <= ST_C_RA;
          end
        end
        ST_C_FIN: state <= ST_C_LCA;
        ST_C_LCA: begin
          lca   <= jn;
          state <= ST_F_RD;
        end
        ST_F_RD: state <= ST_F_DIST;
        ST_F_DIST: begin
          res_anc  <= lca;
          // clamp at zero when the stored depths disagree
          res_dist <= (sum < twice_d) ? '0 : sum - twice_d;
          state    <= ST_Q_OUT;
        end
        ST_Q_OUT: begin
          // hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            out_anc       <= res_anc;
            out_dist      <= res_dist;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {(M_DATA_W - NODE_W - DIST_W)'(0), out_dist, out_anc};

endmodule

`default_nettype wire

>>> src/bllca_check.sv
// Port-level checker for binary_lifting_lca, bound to the top level below.
// Depends on bllca_pkg.
`default_nettype none

module bllca_check (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [bllca_pkg::S_DATA_W-1:0] s_axis_tdata,
  input wire logic                           s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [bllca_pkg::M_DATA_W-1:0] m_axis_tdata
);

  import bllca_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // one word in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> !s_axis_tready)
    else $error("input accepted while a word is in work");

  // no result can come out right after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> !$rose(m_axis_tvalid))
    else $error("result appeared too soon after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  // distance never exceeds the sum of two saturated depths
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[NODE_W+DIST_W-1:NODE_W] != {DIST_W{1'b1}})
    else $error("distance out of range");

endmodule

bind binary_lifting_lca bllca_check u_bllca_check (.*);

`default_nettype wire

>>> dv/tb_binary_lifting_lca.sv
// Self-checking bench for binary_lifting_lca: drives attach and query words, predicts
// each common ancestor and path length from its own copy of the lifting tables.
// Depends on bllca_pkg and the binary_lifting_lca RTL.
`timescale 1ns / 1ps

module tb_binary_lifting_lca;
  import bllca_pkg::*;

  localparam int MAX_NODES    = 1023;
  localparam int LEVELS       = 10;
  localparam int DEPTH_CAP    = 1023;
  localparam int RANDOM_WORDS = 560;
  localparam int LONG_HOLD    = 800;
  // Longest query occupancy of the top level, in clock cycles.
  localparam int QUERY_CYCLES = 6 * LEVELS + 10;

  typedef logic [NODE_W-1:0] node_t;
  typedef struct packed {
    node_t             ancestor;
    logic [DIST_W-1:0] distance;
  } lca_result_t;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [9:0] first_node, [19:10] second_node, [23:20] zero
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  // [0] opcode
  logic                s_axis_tuser  = OP_ATTACH;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [9:0] ancestor_node, [20:10] distance, [23:21] zero
  logic [M_DATA_W-1:0] m_axis_tdata;

  binary_lifting_lca #(
    .MAX_NODES(MAX_NODES),
    .LEVELS   (LEVELS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the block's tables. Node 0 is the sentinel: depth 0 and
  // every ancestor 0. attached[] only steers stimulus away from nodes whose
  // entries the block has never written.
  node_t       ancestor_tbl [0:MAX_NODES][0:LEVELS-1];
  node_t       depth_tbl    [0:MAX_NODES];
  bit          attached     [0:MAX_NODES];
  lca_result_t pending_results [$];

  int failures      = 0;
  int burst_left    = 0;
  int hold_requests = 0;

  // Receiver state, owned by the result process below.
  int          hold_served = 0;
  int          hold_left   = 0;
  int          rx_mode     = 0;
  int          rx_left     = 0;
  int          rx_tick     = 0;
  lca_result_t got_result;
  lca_result_t want_result;

  // Link a node under its parent: depth is the parent's plus one, capped, and
  // each jump level is built from the level below of the midway ancestor.
  // Levels are filled in order, so a node linked under itself sees its own new
  // entries. Node 0 is never linked.
  function automatic void link_node(node_t node, node_t parent);
    int    d;
    int    i;
    node_t mid;
    if (node == '0) return;
    d = depth_tbl[parent] + 1;
    if (d > DEPTH_CAP) d = DEPTH_CAP;
    depth_tbl[node] = node_t'(d);
    ancestor_tbl[node][0] = parent;
    for (i = 1; i < LEVELS; i++) begin
      mid = ancestor_tbl[node][i-1];
      ancestor_tbl[node][i] = ancestor_tbl[mid][i-1];
    end
    attached[node] = 1'b1;
  endfunction

  // Lift the deeper node to the shallower depth, then lift both while their
  // ancestors differ. The distance uses the depths of the queried nodes and
  // clamps at zero when stale depths after a re-link would make it negative.
  function automatic lca_result_t lowest_common(node_t qa, node_t qb);
    node_t       a, b, t, ua, ub;
    int          i;
    int          path_len;
    lca_result_t r;
    a = qa;
    b = qb;
    if (depth_tbl[b] > depth_tbl[a]) begin
      t = a;
      a = b;
      b = t;
    end
    for (i = LEVELS - 1; i >= 0; i--) begin
      ua = ancestor_tbl[a][i];
      if (depth_tbl[ua] >= depth_tbl[b]) a = ua;
    end
    if (a != b) begin
      for (i = LEVELS - 1; i >= 0; i--) begin
        ua = ancestor_tbl[a][i];
        ub = ancestor_tbl[b][i];
        if (ua != ub) begin
          a = ua;
          b = ub;
        end
      end
      a = ancestor_tbl[a][0];
    end
    path_len = int'(depth_tbl[qa]) + int'(depth_tbl[qb]) - 2 * int'(depth_tbl[a]);
    if (path_len < 0) path_len = 0;
    r.ancestor = a;
    r.distance = path_len[DIST_W-1:0];
    return r;
  endfunction

  function automatic node_t any_attached();
    node_t n;
    do n = node_t'($urandom_range(1, MAX_NODES)); while (!attached[n]);
    return n;
  endfunction

  // Offer one word and hold it until the block takes it. Between bursts,
  // drop valid for a random gap; now and then run a long burst with no gaps.
  // Call only right after a rising edge.
  task automatic send_word(logic op, node_t first, node_t second);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 10);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(S_DATA_W - 2 * NODE_W){1'b0}}, second, first};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    // Word accepted at this edge: advance the shadow tables or queue the answer.
    if (op == OP_ATTACH) link_node(first, second);
    else pending_results.insert(pending_results.size(), lowest_common(first, second));
  endtask

  // Result side: check each accepted word against the oldest expectation,
  // then pick the next ready value. A requested hold keeps ready low until its
  // countdown from LONG_HOLD runs out; otherwise switch at random between
  // always-ready, random and mostly-stalled stretches of random length.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_result.ancestor = m_axis_tdata[NODE_W-1:0];
      got_result.distance = m_axis_tdata[NODE_W +: DIST_W];
      if (pending_results.size() == 0) begin
        $error("unexpected result word: ancestor_node %0d distance %0d",
               got_result.ancestor, got_result.distance);
        failures++;
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.ancestor !== want_result.ancestor) begin
          $error("ancestor_node: expected %0d, got %0d",
                 want_result.ancestor, got_result.ancestor);
          failures++;
        end
        if (got_result.distance !== want_result.distance) begin
          $error("distance: expected %0d, got %0d",
                 want_result.distance, got_result.distance);
          failures++;
        end
      end
    end

    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      case (rx_mode)
        0: begin
          m_axis_tready <= 1'b1;
        end
        1: begin
          m_axis_tready <= ($urandom_range(0, 99) < 55);
        end
        default: begin
          m_axis_tready <= (rx_tick % 5 == 0);
        end
      endcase
    end
  end

  // Small hand-built tree: a root, siblings, ancestor pairs in both orders,
  // the sentinel as second node, node 0 attach (ignored), the top node
  // number, a re-link that leaves children with stale depths, and a self
  // link whose distance would come out negative.
  task automatic test_directed();
    send_word(OP_ATTACH, 10'd1,    10'd0);
    send_word(OP_ATTACH, 10'd2,    10'd1);
    send_word(OP_ATTACH, 10'd3,    10'd1);
    send_word(OP_ATTACH, 10'd4,    10'd2);
    send_word(OP_ATTACH, 10'd5,    10'd4);
    send_word(OP_ATTACH, 10'd1023, 10'd3);
    send_word(OP_ATTACH, 10'd512,  10'd5);
    send_word(OP_ATTACH, 10'd200,  10'd3);
    send_word(OP_ATTACH, 10'd682,  10'd1023);
    send_word(OP_ATTACH, 10'd341,  10'd682);
    send_word(OP_QUERY,  10'd4,    10'd3);
    send_word(OP_QUERY,  10'd5,    10'd5);
    send_word(OP_QUERY,  10'd512,  10'd1);
    send_word(OP_QUERY,  10'd1,    10'd512);
    send_word(OP_QUERY,  10'd1023, 10'd512);
    send_word(OP_QUERY,  10'd1,    10'd0);
    send_word(OP_QUERY,  10'd341,  10'd200);
    // The sentinel must survive an attach aimed at it.
    send_word(OP_ATTACH, 10'd0,    10'd1023);
    send_word(OP_QUERY,  10'd1023, 10'd0);
    // Move a subtree root deeper; its children keep their old entries.
    send_word(OP_ATTACH, 10'd3,    10'd512);
    send_word(OP_QUERY,  10'd1023, 10'd200);
    send_word(OP_QUERY,  10'd1023, 10'd3);
    // Self loop: every ancestor is the node itself, distance clamps at zero.
    send_word(OP_ATTACH, 10'd7,    10'd1);
    send_word(OP_ATTACH, 10'd7,    10'd7);
    send_word(OP_QUERY,  10'd7,    10'd1);
  endtask

  // Grow random trees, each hung under the sentinel or grafted onto an
  // existing node, mostly extending recent nodes so paths get deep. Then
  // query mostly within the tree, sometimes against any node or the sentinel,
  // with the odd ignored node 0 attach mixed in.
  task automatic test_random_trees();
    node_t members [$];
    node_t n, p;
    int    words, k, j, q, lo;
    words = 0;
    while (words < RANDOM_WORDS) begin
      members.delete();
      k = $urandom_range(3, 40);
      n = node_t'($urandom_range(1, MAX_NODES));
      p = ($urandom_range(0, 2) == 0) ? any_attached() : node_t'(0);
      send_word(OP_ATTACH, n, p);
      members.insert(members.size(), n);
      for (j = 1; j < k; j++) begin
        n = node_t'($urandom_range(1, MAX_NODES));
        lo = (members.size() > 3) ? members.size() - 3 : 0;
        if ($urandom_range(0, 9) < 6) p = members[$urandom_range(lo, members.size() - 1)];
        else p = members[$urandom_range(0, members.size() - 1)];
        send_word(OP_ATTACH, n, p);
        members.insert(members.size(), n);
      end
      words += k;
      q = $urandom_range(k / 2 + 1, 2 * k);
      for (j = 0; j < q; j++) begin
        case ($urandom_range(0, 19))
          0: begin
            send_word(OP_QUERY, members[$urandom_range(0, members.size() - 1)], '0);
            words++;
          end
          1, 2: begin
            send_word(OP_QUERY, members[$urandom_range(0, members.size() - 1)],
                      any_attached());
            words++;
          end
          3: begin
            send_word(OP_ATTACH, '0, members[$urandom_range(0, members.size() - 1)]);
          end
          default: begin
            send_word(OP_QUERY, members[$urandom_range(0, members.size() - 1)],
                      members[$urandom_range(0, members.size() - 1)]);
            words++;
          end
        endcase
      end
    end
  endtask

  // Hold the result side off for a long stretch while queries keep coming,
  // so the output register fills and the block stalls its input.
  task automatic test_output_stall();
    hold_requests++;
    repeat (12) send_word(OP_QUERY, any_attached(), any_attached());
  endtask

  // Chain every node in random order, so the tip sits at depth 1023 and every
  // jump level is used. Then hang nodes below the tip, where depth saturates.
  task automatic test_deep_chain();
    node_t order [MAX_NODES];
    node_t t, x;
    int    i, j;
    for (i = 0; i < MAX_NODES; i++) order[i] = node_t'(i + 1);
    for (i = MAX_NODES - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    send_word(OP_ATTACH, order[0], '0);
    for (i = 1; i < MAX_NODES; i++) send_word(OP_ATTACH, order[i], order[i-1]);
    send_word(OP_QUERY, order[MAX_NODES-1], order[0]);
    send_word(OP_QUERY, order[0], order[MAX_NODES-1]);
    send_word(OP_QUERY, order[MAX_NODES-1], '0);
    repeat (16) begin
      send_word(OP_QUERY, order[$urandom_range(0, MAX_NODES - 1)],
                order[$urandom_range(0, MAX_NODES - 1)]);
    end
    x = order[$urandom_range(0, MAX_NODES - 2)];
    send_word(OP_ATTACH, x, order[MAX_NODES-1]);
    send_word(OP_QUERY, x, order[MAX_NODES-1]);
    send_word(OP_QUERY, x, order[0]);
    send_word(OP_QUERY, x, '0);
    send_word(OP_ATTACH, order[0], x);
    send_word(OP_QUERY, order[0], order[MAX_NODES/2]);
    send_word(OP_QUERY, order[MAX_NODES-1], x);
  endtask

  initial begin
    int i, j, waited;
    for (i = 0; i <= MAX_NODES; i++) begin
      depth_tbl[i] = '0;
      attached[i]  = 1'b0;
      for (j = 0; j < LEVELS; j++) ancestor_tbl[i][j] = '0;
    end
    attached[0] = 1'b1;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_trees();
    test_output_stall();
    test_deep_chain();

    // Drain: wait out every outstanding answer, then keep waiting to catch
    // stray words.
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * QUERY_CYCLES) @(posedge clk);

    if (pending_results.size() == 0 && failures == 0) begin
      $display("tb_binary_lifting_lca OK");
    end else begin
      if (pending_results.size() != 0)
        $error("%0d query results never arrived", pending_results.size());
      $display("tb_binary_lifting_lca NOT OK");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb_binary_lifting_lca NOT OK");
    $finish;
  end

endmodule
